/* hdl/g2cf_pkg.sv */
// Shared types and constants for the grayscale 2D correlation filter.
package g2cf_pkg;

  localparam int MAX_WIDTH_D  = 128;
  localparam int MAX_HEIGHT_D = 128;
  localparam int MAX_KERNEL_D = 7;

  typedef enum logic [1:0] {
    OP_PIX  = 2'd0,
    OP_COEF = 2'd1,
    OP_CALC = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CFG_BORDER = 3'd0,
    CFG_IW     = 3'd1,
    CFG_IH     = 3'd2,
    CFG_KW     = 3'd3,
    CFG_KH     = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    BM_ZERO = 2'd0,
    BM_REPL = 2'd1,
    BM_REFL = 2'd2,
    BM_WRAP = 2'd3
  } bmode_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_RUN  = 2'd1,
    BK_DRAIN = 2'd2,
    BK_OUT  = 2'd3
  } bk_state_t;

  // Classified command handed from front to back.
  typedef struct packed {
    op_t         op;
    logic [6:0]  row;
    logic [6:0]  col;
    logic [7:0]  pixel;
    logic [5:0]  cidx;
    logic [15:0] cval;
  } cmd_t;

endpackage

/* hdl/g2cf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module g2cf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/g2cf_front.sv */
// Front end: accepts input transfers, drops no-op items, queues commands.
module g2cf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [47:0]         in_tdata,
  output logic                q_valid,
  input  logic                q_pop,
  output g2cf_pkg::cmd_t      q_cmd
);
  import g2cf_pkg::*;

  localparam int QD = 4;

  cmd_t       q_mem_r [QD];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  cmd_t       cin;
  logic       push;

  assign cin.op    = op_t'(in_tdata[1:0]);
  assign cin.row   = in_tdata[8:2];
  assign cin.col   = in_tdata[15:9];
  assign cin.pixel = in_tdata[23:16];
  assign cin.cidx  = in_tdata[29:24];
  assign cin.cval  = in_tdata[45:30];

  assign in_tready = (cnt_r != 3'(QD));
  assign push      = in_tvalid && in_tready && (cin.op != OP_NONE);
  assign q_valid   = (cnt_r != 3'd0);
  assign q_cmd     = q_mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= cin;
    end
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 2'd1;
      if (q_pop) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(push) - 3'(q_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 3'(QD) |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(QD)) else $error("queue count out of range");
endmodule

/* hdl/g2cf_back.sv */
// Back end: frame and coefficient stores, tap sequencer and MAC.
module g2cf_back #(
  parameter int MAX_WIDTH  = g2cf_pkg::MAX_WIDTH_D,
  parameter int MAX_HEIGHT = g2cf_pkg::MAX_HEIGHT_D,
  parameter int MAX_KERNEL = g2cf_pkg::MAX_KERNEL_D
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_pop,
  input  g2cf_pkg::cmd_t q_cmd,
  input  logic [1:0]     border_mode,
  input  logic [7:0]     image_width,
  input  logic [7:0]     image_height,
  input  logic [2:0]     kernel_width,
  input  logic [2:0]     kernel_height,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [23:0]    out_tdata
);
  import g2cf_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int FD  = MAX_WIDTH * MAX_HEIGHT;
  localparam int FA  = $clog2(FD);
  localparam int KD  = MAX_KERNEL * MAX_KERNEL;
  localparam int KA  = $clog2(KD);
  localparam int DW  = (CW > RW ? CW : RW) + 3; // signed coordinate width

  bk_state_t st_r, st_nxt;

  // effective sizes
  logic [7:0] w_e, h_e;
  logic [3:0] kw_e, kh_e;
  logic [2:0] hw, hh;
  always_comb begin
    w_e = (image_width == 8'd0) ? 8'd1 :
          (32'(image_width) > MAX_WIDTH) ? 8'(MAX_WIDTH) : image_width;
    h_e = (image_height == 8'd0) ? 8'd1 :
          (32'(image_height) > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : image_height;
    kw_e = (kernel_width == 3'd0) ? 4'd1 :
           (32'(kernel_width) > MAX_KERNEL) ? 4'(MAX_KERNEL) : {1'b0, kernel_width};
    kh_e = (kernel_height == 3'd0) ? 4'd1 :
           (32'(kernel_height) > MAX_KERNEL) ? 4'(MAX_KERNEL) : {1'b0, kernel_height};
    hw = 3'((kw_e - 4'd1) >> 1);
    hh = 3'((kh_e - 4'd1) >> 1);
  end

  // tap indices and request
  logic [3:0] ti_r, tj_r;
  logic [6:0] row_r, col_r;
  logic signed [31:0] sum_r;
  logic [7:0] res_r;

  // tap pipe: flags line up with the registered store read data
  logic v1_r, z1_r, last1_r;

  function automatic logic signed [DW-1:0] map_c(input logic signed [DW-1:0] p,
      input logic signed [DW-1:0] n, input logic [1:0] bm, output logic zero);
    logic signed [DW-1:0] q;
    zero = 1'b0;
    q = p;
    if (p < 0 || p >= n) begin
      case (bm)
        BM_ZERO: zero = 1'b1;
        BM_REPL: q = (p < 0) ? '0 : n - 1;
        BM_REFL: begin
          q = (p < 0) ? DW'(-p - 1) : DW'(2 * n - 1 - p);
          if (q < 0) q = '0;
          if (q >= n) q = n - 1;
        end
        default: begin
          // a frame smaller than the half kernel may need several wraps
          for (int k = 0; k < (MAX_KERNEL - 1) / 2; k++) begin
            if (q < 0) q = q + n;
            else if (q >= n) q = q - n;
          end
        end
      endcase
    end
    return q;
  endfunction

  logic signed [DW-1:0] pr, pc, mr, mc;
  logic zr, zc, tap_go, tap_last;
  logic [FA-1:0] frd_addr;
  logic [KA-1:0] crd_addr;
  logic [6:0]    ci;
  always_comb begin
    pr = DW'(signed'({1'b0, row_r})) + DW'(signed'({1'b0, ti_r})) - DW'(signed'({1'b0, hh}));
    pc = DW'(signed'({1'b0, col_r})) + DW'(signed'({1'b0, tj_r})) - DW'(signed'({1'b0, hw}));
    mr = map_c(pr, DW'(signed'({1'b0, h_e})), border_mode, zr);
    mc = map_c(pc, DW'(signed'({1'b0, w_e})), border_mode, zc);
    ci = 7'(ti_r * kw_e) + 7'(tj_r);
    tap_go   = (st_r == BK_RUN);
    tap_last = (ti_r == 4'(2 * hh)) && (tj_r == 4'(2 * hw));
  end

  // store writes
  logic fwe, cwe;
  logic [7:0] fr_data;
  logic [15:0] cr_data;
  assign fwe = (st_r == BK_IDLE) && q_valid && (q_cmd.op == OP_PIX) &&
               (32'(q_cmd.row) < MAX_HEIGHT) && (32'(q_cmd.col) < MAX_WIDTH);
  assign cwe = (st_r == BK_IDLE) && q_valid && (q_cmd.op == OP_COEF) &&
               (32'(q_cmd.cidx) < KD);
  assign frd_addr = FA'(mr) * FA'(MAX_WIDTH) + FA'(mc);
  assign crd_addr = KA'(ci);

  g2cf_ram #(.WIDTH(8), .DEPTH(FD)) u_frame (
    .clk(clk), .we(fwe),
    .waddr(FA'(q_cmd.row) * FA'(MAX_WIDTH) + FA'(q_cmd.col)),
    .wdata(q_cmd.pixel), .raddr(frd_addr), .rdata(fr_data));
  g2cf_ram #(.WIDTH(16), .DEPTH(KD)) u_coef (
    .clk(clk), .we(cwe), .waddr(KA'(q_cmd.cidx)), .wdata(q_cmd.cval),
    .raddr(crd_addr), .rdata(cr_data));

  logic in_frame;
  assign in_frame = ({1'b0, q_cmd.row} < h_e) && ({1'b0, q_cmd.col} < w_e);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE:  if (q_valid && q_cmd.op == OP_CALC && in_frame) st_nxt = BK_RUN;
      BK_RUN:   if (tap_last) st_nxt = BK_DRAIN;
      BK_DRAIN: if (v1_r && last1_r) st_nxt = BK_OUT;
      BK_OUT:   if (out_tready) st_nxt = BK_IDLE;
      default:  st_nxt = BK_IDLE;
    endcase
  end

  assign q_pop      = (st_r == BK_IDLE) && q_valid;
  assign out_tvalid = (st_r == BK_OUT);
  assign out_tdata  = {2'b0, col_r, row_r, res_r};

  // truncating accumulate: (256*s + p*c)/256 toward zero
  logic signed [31:0] prod, tot, nsum;
  always_comb begin
    prod = z1_r ? 32'sd0 : $signed({24'd0, fr_data}) * $signed({{16{cr_data[15]}}, cr_data});
    tot  = (sum_r <<< 8) + prod;
    nsum = (tot < 0) ? -((-tot) >>> 8) : (tot >>> 8);
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      row_r <= q_cmd.row;
      col_r <= q_cmd.col;
    end
    if (v1_r) begin
      sum_r <= nsum;
    end else if (st_r == BK_IDLE) begin
      sum_r <= '0;
    end
    if (v1_r && last1_r) begin
      res_r <= (nsum < 0) ? 8'd0 : (nsum > 32'sd255) ? 8'd255 : nsum[7:0];
    end
    if (!rst_n) begin
      st_r <= BK_IDLE;
      ti_r <= '0; tj_r <= '0;
      v1_r <= 1'b0;
      z1_r <= 1'b0;
      last1_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      v1_r <= tap_go; z1_r <= zr | zc; last1_r <= tap_last;
      if (st_r != BK_RUN) begin
        ti_r <= '0; tj_r <= '0;
      end else if (tj_r == 4'(2 * hw)) begin
        tj_r <= '0; ti_r <= ti_r + 4'd1;
      end else begin
        tj_r <= tj_r + 4'd1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != BK_IDLE |-> !q_pop) else $error("pop while busy");
  a_pipe_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> st_r == BK_RUN || st_r == BK_DRAIN) else $error("stray tap");
endmodule

/* hdl/gray_2d_correlation_filter_unit.sv */
// Top level of the grayscale 2D correlation filter.
// A compute item runs one multiply-accumulate per tap over
// (2*floor((kh-1)/2)+1)*(2*floor((kw-1)/2)+1) taps, one tap at a time as set by
// the single frame memory read port, plus queue pop, pipeline and hand-off steps.
// Commands pass through a four-entry queue, so the input side keeps taking
// items while a compute runs, until the queue is full.
// Frame store and coefficient table are not cleared; read only written entries.
module gray_2d_correlation_filter_unit #(
  parameter int MAX_WIDTH  = g2cf_pkg::MAX_WIDTH_D,
  parameter int MAX_HEIGHT = g2cf_pkg::MAX_HEIGHT_D,
  parameter int MAX_KERNEL = g2cf_pkg::MAX_KERNEL_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // op, row, col, pixel, coef_index, coef_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // out_pixel, out_row, out_col
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import g2cf_pkg::*;

  logic [1:0] bm_r;
  logic [7:0] iw_r, ih_r;
  logic [2:0] kw_r, kh_r;
  logic q_valid, q_pop;
  cmd_t q_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bm_r <= 2'd0; iw_r <= 8'd128; ih_r <= 8'd128; kw_r <= 3'd3; kh_r <= 3'd3;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BORDER: bm_r <= cfg_wdata[1:0];
        CFG_IW:     iw_r <= cfg_wdata;
        CFG_IH:     ih_r <= cfg_wdata;
        CFG_KW:     kw_r <= cfg_wdata[2:0];
        CFG_KH:     kh_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  g2cf_front u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd));

  g2cf_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
              .MAX_KERNEL(MAX_KERNEL)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
    .border_mode(bm_r), .image_width(iw_r), .image_height(ih_r),
    .kernel_width(kw_r), .kernel_height(kh_r),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata));
endmodule

/* bench/tb_gray_2d_correlation_filter_unit.sv */
// Self-checking testbench for the grayscale 2D correlation filter unit.
`timescale 1ns / 1ps

module tb_gray_2d_correlation_filter_unit;
  import g2cf_pkg::*;

  localparam int  NUM_PHASES  = 10;
  localparam int  DRAIN_WAIT  = 100;
  localparam int  CYCLE_LIMIT = 2000000;
  localparam int  STORE_DEPTH = MAX_WIDTH_D * MAX_HEIGHT_D;
  localparam int  KTAB_DEPTH  = MAX_KERNEL_D * MAX_KERNEL_D;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;    // op, row, col, pixel, coef_index, coef_value
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;   // out_pixel, out_row, out_col
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_wdata;

  gray_2d_correlation_filter_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // predictor state
  logic [7:0]  img_mem [STORE_DEPTH];
  logic [15:0] ktab [KTAB_DEPTH];
  logic [1:0]  bm_reg;
  logic [7:0]  iw_reg, ih_reg;
  logic [2:0]  kw_reg, kh_reg;

  logic [47:0] pend_items [$];
  logic [23:0] exp_pixels [$];
  int          mismatches;
  int          n_results;
  int          n_computes;
  int          cycles;
  bit          long_hold_req;
  bit          sender_hold;

  function automatic int eff_size(int v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // returns 0 when the tap reads as zero
  function automatic bit map_pos(int p, int n, output int q);
    q = p;
    if (p >= 0 && p < n) return 1'b1;
    case (bmode_t'(bm_reg))
      BM_ZERO: return 1'b0;
      BM_REPL: q = (p < 0) ? 0 : n - 1;
      BM_REFL: begin
        q = (p < 0) ? (-p - 1) : (2 * n - 1 - p);
        if (q < 0) q = 0;
        if (q >= n) q = n - 1;
      end
      default: begin
        q = p % n;
        if (q < 0) q += n;
      end
    endcase
    return 1'b1;
  endfunction

  task automatic filter_predict(input logic [47:0] d);
    op_t         op;
    int          row, col, w, h, kw, kh, hw, hh, r, c, ci;
    longint      sum, pix, coef;
    logic [15:0] kv;
    op  = op_t'(d[1:0]);
    row = d[8:2];
    col = d[15:9];
    case (op)
      OP_PIX:  img_mem[row * MAX_WIDTH_D + col] = d[23:16];
      OP_COEF: if (d[29:24] < KTAB_DEPTH) ktab[d[29:24]] = d[45:30];
      OP_CALC: begin
        w  = eff_size(iw_reg, MAX_WIDTH_D);
        h  = eff_size(ih_reg, MAX_HEIGHT_D);
        kw = eff_size(kw_reg, MAX_KERNEL_D);
        kh = eff_size(kh_reg, MAX_KERNEL_D);
        hw = (kw - 1) / 2;
        hh = (kh - 1) / 2;
        sum = 0;
        if (row < h && col < w) begin
          for (int i = -hh; i <= hh; i++) begin
            for (int j = -hw; j <= hw; j++) begin
              ci   = (i + hh) * kw + (j + hw);
              kv   = ktab[ci];
              coef = $signed(kv);
              pix  = 0;
              if (map_pos(row + i, h, r) && map_pos(col + j, w, c))
                pix = img_mem[r * MAX_WIDTH_D + c];
              sum = (sum * 256 + pix * coef) / 256;
            end
          end
          if (sum < 0) sum = 0;
          if (sum > 255) sum = 255;
          exp_pixels.push_back({col[6:0], row[6:0], sum[7:0]});
          n_computes++;
        end
      end
      default: ;
    endcase
  endtask

  function automatic logic [47:0] make_item(op_t op, int row, int col, int pix,
                                            int ci, int cv);
    logic [47:0] d;
    d = '0;
    d[1:0]   = op;
    d[8:2]   = row[6:0];
    d[15:9]  = col[6:0];
    d[23:16] = pix[7:0];
    d[29:24] = ci[5:0];
    d[45:30] = cv[15:0];
    return d;
  endfunction

  function automatic logic [47:0] rand_item(op_t op);
    return make_item(op, $urandom_range(0, 127), $urandom_range(0, 127),
                     $urandom_range(0, 255), $urandom_range(0, 63), $urandom);
  endfunction

  // mostly modest gains so results do not sit on the clamp rails
  function automatic int rand_coef();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return int'($urandom_range(0, 700)) - 300;
  endfunction

  // ---------------- driver ----------------
  logic [47:0] cur_item;
  bit          took;
  int          burst_left, gap_left;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      filter_predict(in_tdata);
      took = 1'b1;
    end
  end

  always @(negedge clk) begin
    logic nv;
    if (!rst_n) begin
      nv = 1'b0;
    end else if (in_tvalid && !took) begin
      nv = 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
      nv = 1'b0;
    end else if (pend_items.size() > 0 && !sender_hold) begin
      cur_item = pend_items.pop_front();
      nv = 1'b1;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end
    end else begin
      nv = 1'b0;
    end
    took = 1'b0;
    in_tvalid <= nv;
    in_tdata  <= cur_item;
  end

  // ---------------- receiver ----------------
  int rx_left, long_left;
  bit rx_on;

  always @(negedge clk) begin
    if (long_hold_req && long_left == 0) begin
      long_hold_req = 1'b0;
      long_left = 600;
    end
    if (long_left > 0) begin
      long_left--;
      out_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_on = ~rx_on;
        rx_left = rx_on ? $urandom_range(1, 30) :
                  (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
      end
      if (rx_left > 0) rx_left--;
      out_tready <= rx_on;
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    logic [23:0] e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end else if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (exp_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        e = exp_pixels.pop_front();
        if (out_tdata[7:0] !== e[7:0] || out_tdata[14:8] !== e[14:8] ||
            out_tdata[21:15] !== e[21:15]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp pix %0d row %0d col %0d, got pix %0d row %0d col %0d",
                     e[7:0], e[14:8], e[21:15],
                     out_tdata[7:0], out_tdata[14:8], out_tdata[21:15]);
        end
      end
    end
  end

  // ---------------- sequencing ----------------
  task automatic cfg_write(cfg_idx_t idx, int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[7:0];
    @(posedge clk);
    case (idx)
      CFG_BORDER: bm_reg = val[1:0];
      CFG_IW:     iw_reg = val[7:0];
      CFG_IH:     ih_reg = val[7:0];
      CFG_KW:     kw_reg = val[2:0];
      CFG_KH:     kh_reg = val[2:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pend_items.size() > 0 || in_tvalid || exp_pixels.size() > 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // phase settings: border, width, height, kernel width, kernel height
  int ph_bm [NUM_PHASES] = '{0, 1, 2, 3, 0, 1, 2, 3, 2, 3};
  int ph_iw [NUM_PHASES] = '{8, 5, 3, 4, 255, 1, 0, 10, 12, 1};
  int ph_ih [NUM_PHASES] = '{8, 6, 2, 3, 1, 128, 9, 10, 7, 1};
  int ph_kw [NUM_PHASES] = '{3, 5, 7, 7, 0, 6, 2, 7, 3, 1};
  int ph_kh [NUM_PHASES] = '{3, 3, 7, 5, 7, 4, 7, 7, 5, 1};

  initial begin
    int w, h, sel;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_BORDER;
    cfg_wdata = '0;
    cur_item = '0;
    bm_reg = BM_ZERO; iw_reg = 8'd128; ih_reg = 8'd128; kw_reg = 3'd3; kh_reg = 3'd3;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      cfg_write(CFG_BORDER, ph_bm[p]);
      cfg_write(CFG_IW, ph_iw[p]);
      cfg_write(CFG_IH, ph_ih[p]);
      cfg_write(CFG_KW, ph_kw[p]);
      cfg_write(CFG_KH, ph_kh[p]);
      @(negedge clk);
      cfg_we <= 1'b0;
      w = eff_size(ph_iw[p], MAX_WIDTH_D);
      h = eff_size(ph_ih[p], MAX_HEIGHT_D);

      // every tap reads inside the frame, so fill it and the whole table first
      for (int i = 0; i < KTAB_DEPTH; i++)
        pend_items.push_back(make_item(OP_COEF, 0, 0, 0, i, rand_coef()));
      for (int r = 0; r < h; r++)
        for (int c = 0; c < w; c++)
          pend_items.push_back(make_item(OP_PIX, r, c, $urandom_range(0, 255), 0, 0));

      if (p == 0) begin
        pend_items.push_back(make_item(OP_PIX, 0, 0, 255, 63, 0));
        pend_items.push_back(make_item(OP_PIX, 7, 7, 0, 0, 0));
        pend_items.push_back(make_item(OP_COEF, 127, 127, 255, 4, 16'h7FFF));
        pend_items.push_back(make_item(OP_CALC, 0, 0, 0, 0, 0));
        pend_items.push_back(make_item(OP_COEF, 0, 0, 0, 4, 16'h8000));
        pend_items.push_back(make_item(OP_CALC, 7, 7, 255, 63, 16'hFFFF));
        pend_items.push_back(make_item(OP_COEF, 0, 0, 0, 4, 256));
        pend_items.push_back(make_item(OP_CALC, 3, 4, 0, 0, 0));
        pend_items.push_back(make_item(OP_CALC, 0, 7, 0, 0, 0));
        pend_items.push_back(make_item(OP_CALC, 7, 0, 0, 0, 0));
        pend_items.push_back(make_item(OP_CALC, 127, 127, 0, 0, 0));  // outside frame
        pend_items.push_back(make_item(OP_CALC, 8, 0, 0, 0, 0));      // outside frame
        pend_items.push_back(make_item(OP_COEF, 0, 0, 0, 63, 16'h1234)); // ignored
        pend_items.push_back(make_item(OP_COEF, 0, 0, 0, 49, 16'hFFFF)); // ignored
        pend_items.push_back(make_item(OP_NONE, 127, 127, 255, 63, 16'hFFFF));
        pend_items.push_back(make_item(OP_CALC, 4, 4, 0, 0, 0));
      end

      if (p == 3) long_hold_req = 1'b1;
      for (int k = 0; k < 70; k++) begin
        sel = $urandom_range(0, 99);
        if (sel < 45)
          pend_items.push_back(($urandom_range(0, 7) == 0) ? rand_item(OP_CALC) :
            make_item(OP_CALC, $urandom_range(0, h - 1), $urandom_range(0, w - 1),
                      $urandom_range(0, 255), $urandom_range(0, 63), $urandom));
        else if (sel < 72)
          pend_items.push_back(make_item(OP_PIX, $urandom_range(0, h - 1),
            $urandom_range(0, w - 1), $urandom_range(0, 255), $urandom_range(0, 63),
            $urandom));
        else if (sel < 84)
          pend_items.push_back(make_item(OP_COEF, $urandom_range(0, 127),
            $urandom_range(0, 127), $urandom_range(0, 255), $urandom_range(0, 63),
            rand_coef()));
        else if (sel < 92)
          pend_items.push_back(rand_item(OP_NONE));
        else
          pend_items.push_back(rand_item(OP_PIX));  // anywhere in the store
      end

      // sender waits for every result before going on
      while (pend_items.size() > 40) @(posedge clk);
      sender_hold = 1'b1;
      while (exp_pixels.size() > 0 || in_tvalid) @(posedge clk);
      sender_hold = 1'b0;
      wait_idle();
    end

    $display("covered %0d phases: all border modes, frame sizes 1..128, kernels 0..7",
             NUM_PHASES);
    $display("%0d pixels computed, %0d results checked", n_computes, n_results);
    if (mismatches == 0 && exp_pixels.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* gray_2d_correlation_filter_unit.f */
hdl/g2cf_pkg.sv
hdl/g2cf_ram.sv
hdl/g2cf_front.sv
hdl/g2cf_back.sv
hdl/gray_2d_correlation_filter_unit.sv
bench/tb_gray_2d_correlation_filter_unit.sv
